// ===== rtl/ppgse_pkg.sv =====
// ppgse_pkg: shared constants and types for the pulse and spo2 estimator
// no dependencies; used by the channel interfaces and the top level
package ppgse_pkg;

  localparam int SAMPLE_BITS_DEF = 18;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN  = 3'd0,
    REG_DC_KEEP     = 3'd1,
    REG_SPO2_KEEP   = 3'd2,
    REG_RATE_WEIGHT = 3'd3,
    REG_MIN_GAP     = 3'd4
  } cfg_reg_t;

  localparam logic [16:0] W_ONE      = 17'h10000;
  localparam logic [31:0] MS_PER_MIN = 32'd60000;
  localparam int          R_OFFSET   = 26214;
  localparam int          SLOPE      = 5965;
  localparam int          HUNDRED    = 25600;

  localparam logic [9:0]  WINDOW_LEN_RST  = 10'd100;
  localparam logic [15:0] DC_KEEP_RST     = 16'd62259;
  localparam logic [15:0] SPO2_KEEP_RST   = 16'd45875;
  localparam logic [15:0] RATE_WEIGHT_RST = 16'd19661;
  localparam logic [10:0] MIN_GAP_RST     = 11'd300;

endpackage

// ===== rtl/ppgse_if.sv =====
// ppgse_in_if, ppgse_out_if: valid/ready channels for samples and results
// depends on ppgse_pkg
interface ppgse_in_if import ppgse_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red_sample;
  logic [SAMPLE_BITS-1:0] ir_sample;
  logic [31:0]            time_ms;

  modport source (output valid, output red_sample, output ir_sample, output time_ms,
                  input ready);
  modport sink   (input valid, input red_sample, input ir_sample, input time_ms,
                  output ready);
endinterface

interface ppgse_out_if;
  logic               valid;
  logic               ready;
  logic               beat;
  logic [7:0]         rate_bpm;
  logic [7:0]         smooth_bpm;
  logic               spo2_update;
  logic signed [15:0] spo2_est;

  modport source (output valid, output beat, output rate_bpm, output smooth_bpm,
                  output spo2_update, output spo2_est, input ready);
  modport sink   (input valid, input beat, input rate_bpm, input smooth_bpm,
                  input spo2_update, input spo2_est, output ready);
endinterface

// ===== rtl/ppg_pulse_and_spo2_estimator.sv =====
// ppg_pulse_and_spo2_estimator: dc tracking, beat rate and windowed spo2
// depends on ppgse_pkg and the channel interfaces in ppgse_if.sv
//
//  channel     dir  transaction
//  sample_in   in   red_sample, ir_sample, time_ms
//  result_out  out  beat, rate_bpm, smooth_bpm, spo2_update, spo2_est
//  cfg         in   cfg_we, cfg_index, cfg_data (write only)
//
// one sample at a time through a shared multiplier, a radix-2 divider and a
// bit-pair square root unit. a beat with a long enough gap adds a rate division
// and smoothing; a window close adds the two roots, the ratio division (skipped
// when the ratio saturates) and the spo2 update.
// rst is synchronous; it clears the state and restores config to its defaults.
// sample_in is not ready until the result is loaded in the output register.
module ppg_pulse_and_spo2_estimator import ppgse_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  ppgse_in_if.sink             sample_in,
  ppgse_out_if.source          result_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int XW  = SAMPLE_BITS + FRAC_BITS;
  localparam int DW  = XW - FRAC_BITS / 2;
  localparam int DCS = (XW > 32) ? (XW - 32) : 0;
  localparam int DDW = XW - DCS;
  localparam int OW  = ((XW > 33) ? XW : 33) + 1;
  localparam int PW  = 2 * OW;

  typedef enum logic [4:0] {
    S_IDLE, S_DR1, S_DR2, S_DR3, S_DI2, S_DI3, S_SQR, S_SQI, S_DIV,
    S_SM1, S_SM2, S_SM3, S_WIN, S_RTR, S_RTI, S_TOP, S_BOT, S_CHK,
    S_SP1, S_SP2, S_SP3, S_SP4, S_FIN
  } state_t;

  state_t state;

  logic [9:0]  win_len;
  logic [15:0] dc_keep, spo2_keep, rate_weight;
  logic [10:0] min_gap;

  logic [XW-1:0]      dc_red, dc_ir, xr, xi;
  logic [63:0]        sum_red, sum_ir;
  logic [9:0]         win_cnt;
  logic               prev_neg, beat_seen;
  logic [31:0]        last_beat, now;
  logic [7:0]         rate_reg, smooth;
  logic signed [15:0] spo2, raw;

  logic signed [OW-1:0] ma, mb;
  logic signed [PW-1:0] p, acc;

  logic [63:0] div_rem, div_dvs;
  logic [31:0] div_dvd, div_q, ratio;
  logic [4:0]  div_cnt;
  logic        div_ratio;

  logic [63:0] sq_v, sq_r, sq_bit;
  logic [31:0] s_red, s_ir;

  logic beat_f, upd_f, out_valid;
  logic       o_beat, o_upd;
  logic [7:0] o_rate, o_smooth;
  logic signed [15:0] o_spo2;

  // deviation terms
  logic [XW-1:0] m_red, m_ir;
  logic [DW-1:0] d_red, d_ir;
  logic          big_red, big_ir;
  always_comb begin
    m_red   = (xr >= dc_red) ? xr - dc_red : dc_red - xr;
    m_ir    = (xi >= dc_ir) ? xi - dc_ir : dc_ir - xi;
    d_red   = DW'(m_red >> (FRAC_BITS / 2));
    d_ir    = DW'(m_ir >> (FRAC_BITS / 2));
    big_red = 64'(d_red) > 64'hFFFF_FFFF;
    big_ir  = 64'(d_ir) > 64'hFFFF_FFFF;
  end

  logic [63:0] term;
  logic [64:0] sat_sum;
  always_comb begin
    term    = (state == S_SQR ? big_red : big_ir) ? '1 : p[63:0];
    sat_sum = {1'b0, (state == S_SQR) ? sum_red : sum_ir} + {1'b0, term};
  end

  // divider step
  logic [64:0] div_t;
  logic        div_ge;
  logic [63:0] div_rem_next;
  logic [31:0] div_q_next;
  always_comb begin
    div_t        = {div_rem, div_dvd[31]};
    div_ge       = div_t >= {1'b0, div_dvs};
    div_rem_next = div_ge ? 64'(div_t - {1'b0, div_dvs}) : div_t[63:0];
    div_q_next   = {div_q[30:0], div_ge};
  end

  // square root step
  logic [64:0] sq_sum;
  logic        sq_ge;
  logic [63:0] sq_v_next, sq_r_next;
  always_comb begin
    sq_sum    = {1'b0, sq_r} + {1'b0, sq_bit};
    sq_ge     = {1'b0, sq_v} >= sq_sum;
    sq_v_next = sq_ge ? sq_v - sq_sum[63:0] : sq_v;
    sq_r_next = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;
  end

  logic              neg_c, beat_c;
  logic [31:0]       gap;
  logic [9:0]        win_cnt_next;
  logic signed [PW-1:0] sum_p, raw_full;
  logic signed [33:0] diff;
  logic [DDW-1:0]    dd_red, dd_ir;
  logic              cap;
  always_comb begin
    neg_c        = dc_ir > xi;
    beat_c       = prev_neg & ~neg_c;
    gap          = now - last_beat;
    win_cnt_next = win_cnt + 10'd1;
    sum_p        = acc + p;
    raw_full     = PW'(HUNDRED) - (p >>> 16);
    diff         = signed'({2'b00, ratio}) - 34'(R_OFFSET);
    dd_red       = DDW'(dc_red >> DCS);
    dd_ir        = DDW'(dc_ir >> DCS);
    cap          = (p[63:0] == '0) || ({16'h0, acc[63:0]} >= {p[63:0], 16'h0});
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_DR1: begin ma = signed'(OW'(dc_red)); mb = signed'(OW'(dc_keep)); end
      S_DR2: begin ma = signed'(OW'(xr)); mb = signed'(OW'(W_ONE - {1'b0, dc_keep})); end
      S_DR3: begin ma = signed'(OW'(dc_ir)); mb = signed'(OW'(dc_keep)); end
      S_DI2: begin ma = signed'(OW'(xi)); mb = signed'(OW'(W_ONE - {1'b0, dc_keep})); end
      S_DI3: begin ma = signed'(OW'(d_red)); mb = signed'(OW'(d_red)); end
      S_SQR: begin ma = signed'(OW'(d_ir)); mb = signed'(OW'(d_ir)); end
      S_SM1: begin
        ma = signed'(OW'(W_ONE - {1'b0, rate_weight}));
        mb = signed'(OW'(smooth));
      end
      S_SM2: begin ma = signed'(OW'(rate_weight)); mb = signed'(OW'(rate_reg)); end
      S_TOP: begin ma = signed'(OW'(s_red)); mb = signed'(OW'(dd_ir)); end
      S_BOT: begin ma = signed'(OW'(s_ir)); mb = signed'(OW'(dd_red)); end
      S_SP1: begin ma = OW'(diff); mb = signed'(OW'(SLOPE)); end
      S_SP2: begin ma = signed'(OW'(spo2_keep)); mb = OW'(spo2); end
      S_SP3: begin ma = signed'(OW'(W_ONE - {1'b0, spo2_keep})); mb = OW'(raw); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      win_len     <= WINDOW_LEN_RST;
      dc_keep     <= DC_KEEP_RST;
      spo2_keep   <= SPO2_KEEP_RST;
      rate_weight <= RATE_WEIGHT_RST;
      min_gap     <= MIN_GAP_RST;
      dc_red      <= '0;
      dc_ir       <= '0;
      sum_red     <= '0;
      sum_ir      <= '0;
      win_cnt     <= '0;
      prev_neg    <= 1'b0;
      beat_seen   <= 1'b0;
      last_beat   <= '0;
      rate_reg    <= '0;
      smooth      <= '0;
      spo2        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_LEN:  win_len     <= cfg_data[9:0];
          REG_DC_KEEP:     dc_keep     <= cfg_data;
          REG_SPO2_KEEP:   spo2_keep   <= cfg_data;
          REG_RATE_WEIGHT: rate_weight <= cfg_data;
          REG_MIN_GAP:     min_gap     <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid && result_out.ready && state != S_FIN) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (sample_in.valid) begin
            xr     <= {sample_in.red_sample, {FRAC_BITS{1'b0}}};
            xi     <= {sample_in.ir_sample, {FRAC_BITS{1'b0}}};
            now    <= sample_in.time_ms;
            beat_f <= 1'b0;
            upd_f  <= 1'b0;
            state  <= S_DR1;
          end
        end
        S_DR1: state <= S_DR2;
        S_DR2: begin acc <= p; state <= S_DR3; end
        S_DR3: begin dc_red <= sum_p[XW+15:16]; state <= S_DI2; end
        S_DI2: begin acc <= p; state <= S_DI3; end
        S_DI3: begin dc_ir <= sum_p[XW+15:16]; state <= S_SQR; end
        S_SQR: begin
          sum_red <= sat_sum[64] ? '1 : sat_sum[63:0];
          state   <= S_SQI;
        end
        S_SQI: begin
          sum_ir   <= sat_sum[64] ? '1 : sat_sum[63:0];
          prev_neg <= neg_c;
          beat_f   <= beat_c;
          if (beat_c) begin
            last_beat <= now;
            beat_seen <= 1'b1;
          end
          if (beat_c && beat_seen && gap >= 32'(min_gap)) begin
            if (gap == '0) begin
              rate_reg <= '0;
              state    <= S_SM1;
            end else begin
              div_rem   <= '0;
              div_dvd   <= MS_PER_MIN;
              div_dvs   <= 64'(gap);
              div_cnt   <= '0;
              div_ratio <= 1'b0;
              state     <= S_DIV;
            end
          end else begin
            state <= S_WIN;
          end
        end
        S_DIV: begin
          div_rem <= div_rem_next;
          div_dvd <= {div_dvd[30:0], 1'b0};
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            if (div_ratio) begin
              ratio <= div_q_next;
              state <= S_SP1;
            end else begin
              rate_reg <= (div_q_next > 32'd255) ? 8'd255 : div_q_next[7:0];
              state    <= S_SM1;
            end
          end
        end
        S_SM1: begin
          if (smooth == '0) begin
            smooth <= rate_reg;
            state  <= S_WIN;
          end else begin
            state <= S_SM2;
          end
        end
        S_SM2: begin acc <= p; state <= S_SM3; end
        S_SM3: begin smooth <= sum_p[23:16]; state <= S_WIN; end
        S_WIN: begin
          win_cnt <= win_cnt_next;
          if (win_len == '0 || win_cnt_next >= win_len) begin
            sq_v   <= sum_red;
            sq_r   <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= S_RTR;
          end else begin
            state <= S_FIN;
          end
        end
        S_RTR: begin
          if (sq_bit[0]) begin
            s_red  <= sq_r_next[31:0];
            sq_v   <= sum_ir;
            sq_r   <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= S_RTI;
          end else begin
            sq_v   <= sq_v_next;
            sq_r   <= sq_r_next;
            sq_bit <= sq_bit >> 2;
          end
        end
        S_RTI: begin
          sq_v   <= sq_v_next;
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            s_ir  <= sq_r_next[31:0];
            state <= S_TOP;
          end
        end
        S_TOP: state <= S_BOT;
        S_BOT: begin acc <= p; state <= S_CHK; end
        S_CHK: begin
          if (cap) begin
            ratio <= '1;
            state <= S_SP1;
          end else begin
            div_rem   <= acc[63:0] >> 16;
            div_dvd   <= {acc[15:0], 16'h0};
            div_dvs   <= p[63:0];
            div_cnt   <= '0;
            div_ratio <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_SP1: state <= S_SP2;
        S_SP2: begin
          if (raw_full > PW'(32767))       raw <= 16'sh7FFF;
          else if (raw_full < -PW'(32768)) raw <= 16'sh8000;
          else                             raw <= raw_full[15:0];
          state <= S_SP3;
        end
        S_SP3: begin acc <= p; state <= S_SP4; end
        S_SP4: begin
          spo2    <= sum_p[31:16];
          sum_red <= '0;
          sum_ir  <= '0;
          win_cnt <= '0;
          upd_f   <= 1'b1;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || result_out.ready) begin
            o_beat    <= beat_f;
            o_rate    <= rate_reg;
            o_smooth  <= smooth;
            o_upd     <= upd_f;
            o_spo2    <= spo2;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_in.ready        = (state == S_IDLE);
  assign result_out.valid       = out_valid;
  assign result_out.beat        = o_beat;
  assign result_out.rate_bpm    = o_rate;
  assign result_out.smooth_bpm  = o_smooth;
  assign result_out.spo2_update = o_upd;
  assign result_out.spo2_est    = o_spo2;

endmodule

// ===== test/tb_ppg_pulse_and_spo2_estimator.sv =====
// tb_ppg_pulse_and_spo2_estimator: self-checking bench for the pulse and spo2 estimator
// drives sample transactions, predicts each result in-bench and compares field by field
// depends on ppgse_pkg, ppgse_if.sv and the top level rtl
`timescale 1ns / 1ps

module tb_ppg_pulse_and_spo2_estimator;
  import ppgse_pkg::*;

  typedef struct packed {
    logic               beat;
    logic [7:0]         rate_bpm;
    logic [7:0]         smooth_bpm;
    logic               spo2_update;
    logic signed [15:0] spo2_est;
  } ppg_result_t;

  typedef struct {
    logic [17:0] red;
    logic [17:0] ir;
    logic [31:0] t;
    bit          known;
    ppg_result_t want;
  } sample_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ppgse_in_if  sample_in ();
  ppgse_out_if result_out ();

  ppg_pulse_and_spo2_estimator dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .result_out (result_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [63:0] m_window_len, m_dc_keep, m_spo2_keep, m_rate_weight, m_min_gap;
  logic [63:0] m_dc_red, m_dc_ir, m_sq_red, m_sq_ir;
  logic [9:0]  m_wcount;
  logic [31:0] m_last_beat;
  logic [7:0]  m_rate, m_smooth;
  bit          m_prev_neg, m_beat_seen;
  longint      m_spo2;

  ppg_result_t expected_results[$];
  int errors;
  int tx_idle, rx_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic logic [63:0] dev_sq(input logic [63:0] xs, input logic [63:0] dc);
    logic [63:0] m;
    m = (xs >= dc) ? xs - dc : dc - xs;
    m = m >> 8;
    if (m > 64'hFFFF_FFFF) return '1;
    return m * m;
  endfunction

  function automatic logic [63:0] ratio_of_ratios();
    logic [63:0] top, bot, q, rem, f;
    top = isqrt(m_sq_red) * (m_dc_ir >> 2);
    bot = isqrt(m_sq_ir) * (m_dc_red >> 2);
    if (bot == 0) return 64'hFFFF_FFFF;
    q = top / bot;
    if (q >= 65536) return 64'hFFFF_FFFF;
    rem = top % bot;
    f = 0;
    for (int k = 0; k < 16; k++) begin
      f = f << 1;
      if (rem >= bot - rem) begin
        rem = rem - (bot - rem);
        f[0] = 1'b1;
      end else begin
        rem = rem + rem;
      end
    end
    return (q << 16) | f;
  endfunction

  task automatic predict_sample(input logic [17:0] red, input logic [17:0] ir,
                                input logic [31:0] now, output ppg_result_t res);
    logic [63:0] xr, xi, rr;
    logic [31:0] gap, r;
    longint diff, raw;
    bit neg, beat, upd;
    xr = {46'd0, red} << 16;
    xi = {46'd0, ir} << 16;
    upd = 0;
    m_dc_red = (m_dc_red * m_dc_keep + xr * (65536 - m_dc_keep)) >> 16;
    m_dc_ir  = (m_dc_ir * m_dc_keep + xi * (65536 - m_dc_keep)) >> 16;
    m_sq_red = sat_sum(m_sq_red, dev_sq(xr, m_dc_red));
    m_sq_ir  = sat_sum(m_sq_ir, dev_sq(xi, m_dc_ir));
    neg = m_dc_ir > xi;
    beat = m_prev_neg && !neg;
    if (beat) begin
      if (m_beat_seen) begin
        gap = now - m_last_beat;
        if (gap >= m_min_gap) begin
          r = (gap == 0) ? 32'd0 : MS_PER_MIN / gap;
          m_rate = (r > 255) ? 8'd255 : r[7:0];
          if (m_smooth == 0) m_smooth = m_rate;
          else begin
            rr = ((65536 - m_rate_weight) * m_smooth + m_rate_weight * m_rate) >> 16;
            m_smooth = rr[7:0];
          end
        end
      end
      m_last_beat = now;
      m_beat_seen = 1;
    end
    m_prev_neg = neg;
    m_wcount = m_wcount + 10'd1;
    if (m_window_len == 0 || m_wcount >= m_window_len) begin
      diff = longint'(ratio_of_ratios()) - R_OFFSET;
      raw = HUNDRED - ((diff * SLOPE) >>> 16);
      if (raw > 32767) raw = 32767;
      if (raw < -32768) raw = -32768;
      m_spo2 = (longint'(m_spo2_keep) * m_spo2 + longint'(65536 - m_spo2_keep) * raw) >>> 16;
      m_sq_red = 0;
      m_sq_ir = 0;
      m_wcount = 0;
      upd = 1;
    end
    res.beat = beat;
    res.rate_bpm = m_rate;
    res.smooth_bpm = m_smooth;
    res.spo2_update = upd;
    res.spo2_est = m_spo2[15:0];
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LEN:  m_window_len  = val[9:0];
      REG_DC_KEEP:     m_dc_keep     = val;
      REG_SPO2_KEEP:   m_spo2_keep   = val;
      REG_RATE_WEIGHT: m_rate_weight = val;
      REG_MIN_GAP:     m_min_gap     = val[10:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [17:0] red, input logic [17:0] ir,
                             input logic [31:0] t, input bit known, input ppg_result_t want);
    ppg_result_t res;
    if ($urandom_range(99) < tx_idle) begin
      sample_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    sample_in.valid <= 1'b1;
    sample_in.red_sample <= red;
    sample_in.ir_sample <= ir;
    sample_in.time_ms <= t;
    do @(posedge clk); while (!sample_in.ready);
    predict_sample(red, ir, t, res);
    if (known && res !== want) begin
      $display("%0t directed row: expected %p, actual %p", $time, want, res);
      errors++;
    end
    expected_results.push_back(res);
  endtask

  task automatic drain();
    sample_in.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= rx_idle);
      if (result_out.valid && result_out.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected transaction: expected none, actual %p", $time,
                   {result_out.beat, result_out.rate_bpm, result_out.smooth_bpm,
                    result_out.spo2_update, result_out.spo2_est});
          errors++;
        end else begin
          ppg_result_t e;
          e = expected_results.pop_front();
          if (result_out.beat !== e.beat) begin
            $display("%0t beat: expected %0d, actual %0d", $time, e.beat, result_out.beat);
            errors++;
          end
          if (result_out.rate_bpm !== e.rate_bpm) begin
            $display("%0t rate_bpm: expected %0d, actual %0d", $time, e.rate_bpm,
                     result_out.rate_bpm);
            errors++;
          end
          if (result_out.smooth_bpm !== e.smooth_bpm) begin
            $display("%0t smooth_bpm: expected %0d, actual %0d", $time, e.smooth_bpm,
                     result_out.smooth_bpm);
            errors++;
          end
          if (result_out.spo2_update !== e.spo2_update) begin
            $display("%0t spo2_update: expected %0d, actual %0d", $time, e.spo2_update,
                     result_out.spo2_update);
            errors++;
          end
          if (result_out.spo2_est !== e.spo2_est) begin
            $display("%0t spo2_est: expected %0d, actual %0d", $time, e.spo2_est,
                     result_out.spo2_est);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    sample_row_t rows[$];
    ppg_result_t zero_res, none;
    logic [17:0] base_r, base_i, amp_r, amp_i, red, ir;
    logic [31:0] t;
    int phase_pos, period, tri_v;
    logic [15:0] cfg_sets[8][5];

    errors = 0;
    tx_idle = 13;
    rx_idle = 55;
    zero_res = '0;
    none = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_WINDOW_LEN;
    cfg_data <= '0;
    sample_in.valid <= 1'b0;
    sample_in.red_sample <= '0;
    sample_in.ir_sample <= '0;
    sample_in.time_ms <= '0;

    m_window_len = 64'(WINDOW_LEN_RST); m_dc_keep = 64'(DC_KEEP_RST);
    m_spo2_keep = 64'(SPO2_KEEP_RST);
    m_rate_weight = 64'(RATE_WEIGHT_RST); m_min_gap = 64'(MIN_GAP_RST);
    m_dc_red = 0; m_dc_ir = 0; m_sq_red = 0; m_sq_ir = 0; m_wcount = 0;
    m_last_beat = 0; m_rate = 0; m_smooth = 0; m_prev_neg = 0; m_beat_seen = 0; m_spo2 = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, first beat, short and long gaps, same-time beat, wrap
    rows.push_back('{18'd0, 18'd0, 32'd0, 1, zero_res});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd1, 1, zero_res});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd2, 0, none});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd3, 0, none});
    rows.push_back('{18'd0, 18'd0, 32'd10, 0, none});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd20, 0, none});
    rows.push_back('{18'd0, 18'd0, 32'd100, 0, none});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd150, 0, none});
    rows.push_back('{18'd0, 18'd0, 32'd400, 0, none});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd500, 0, none});
    rows.push_back('{18'd0, 18'd0, 32'd700, 0, none});
    rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'd1500, 0, none});
    rows.push_back('{18'h2AAAA, 18'd0, 32'hFFFF_FF00, 0, none});
    rows.push_back('{18'h15555, 18'h3FFFF, 32'h0000_0100, 0, none});
    rows.push_back('{18'h3FFFF, 18'd5, 32'h0000_0200, 0, none});
    rows.push_back('{18'd1, 18'h3FFFF, 32'h0000_0200, 0, none});
    rows.push_back('{18'h20000, 18'h20000, 32'h8000_0000, 0, none});
    rows.push_back('{18'h1FFFF, 18'h1FFFF, 32'h7FFF_FFFF, 0, none});
    foreach (rows[k]) send_sample(rows[k].red, rows[k].ir, rows[k].t, rows[k].known,
                                  rows[k].want);
    drain();

    // window, dc keep, spo2 keep, rate weight, min gap
    cfg_sets[0] = '{16'd8,    16'd62259, 16'd45875, 16'd19661, 16'd300};
    cfg_sets[1] = '{16'd1,    16'd0,     16'd0,     16'd0,     16'd1};
    cfg_sets[2] = '{16'd0,    16'd65535, 16'd65535, 16'd65535, 16'd0};
    cfg_sets[3] = '{16'd1023, 16'd60000, 16'd30000, 16'd40000, 16'd2000};
    cfg_sets[4] = '{16'd16,   16'd50000, 16'd45875, 16'd19661, 16'd0};
    cfg_sets[5] = '{16'd5,    16'd65000, 16'd10000, 16'd65535, 16'd100};
    cfg_sets[6] = '{16'd32,   16'd58000, 16'd60000, 16'd1,     16'd250};
    cfg_sets[7] = '{16'd64,   16'd62259, 16'd45875, 16'd19661, 16'd300};

    t = 32'hFFFF_8000;
    for (int p = 0; p < 8; p++) begin
      tx_idle = (p < 3) ? 13 : (p < 6) ? 55 : 0;
      rx_idle = (p < 3) ? 55 : (p < 6) ? 13 : 0;
      write_reg(REG_WINDOW_LEN, cfg_sets[p][0]);
      write_reg(REG_DC_KEEP, cfg_sets[p][1]);
      write_reg(REG_SPO2_KEEP, cfg_sets[p][2]);
      write_reg(REG_RATE_WEIGHT, cfg_sets[p][3]);
      write_reg(REG_MIN_GAP, cfg_sets[p][4]);
      cfg_we <= 1'b0;
      base_r = 18'($urandom_range(18'h3FFFF));
      base_i = 18'($urandom_range(18'h3FFFF));
      amp_r = 18'($urandom_range(18'hFFFF));
      amp_i = 18'($urandom_range(18'hFFFF));
      period = $urandom_range(40, 4);
      phase_pos = 0;
      for (int n = 0; n < 192; n++) begin
        if ($urandom_range(99) < 12) begin
          red = 18'($urandom);
          ir = 18'($urandom);
          t = ($urandom_range(9) == 0) ? $urandom : t + $urandom_range(3000);
        end else begin
          // triangular pulse riding on a baseline, clipped to the sample range
          tri_v = (phase_pos < period / 2) ? phase_pos : period - phase_pos;
          red = (base_r + amp_r * tri_v / period > 18'h3FFFF) ? 18'h3FFFF
                : 18'(base_r + amp_r * tri_v / period);
          ir = (base_i + amp_i * tri_v / period > 18'h3FFFF) ? 18'h3FFFF
               : 18'(base_i + amp_i * tri_v / period);
          t = t + $urandom_range(60);
          phase_pos = (phase_pos + 1) % period;
        end
        send_sample(red, ir, t, 0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
